/* hdl/mpdp_pkg.sv */
// Package: shared types, codes and fp32 helper functions for the dot-product unit
package mpdp_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned AddrWidth = 1;

   localparam logic [31:0] CanonNan = 32'h7FC0_0000;

   typedef enum logic [1:0] {
      FMT_FP32 = 2'd0,
      FMT_FP16 = 2'd1,
      FMT_INT8 = 2'd2,
      FMT_RSVD = 2'd3
   } fmt_type;

   typedef enum logic [0:0] {
      REG_WEIGHT_FORMAT = 1'b0
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_MUL   = 3'd1,
      ST_ADD   = 3'd2,
      ST_SCALE = 3'd3,
      ST_OUT   = 3'd4
   } state_type;

   typedef enum logic [1:0] {
      MUL_ACT_WEIGHT = 2'd0,
      MUL_SUM_SCALE  = 2'd1
   } mulsel_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture input item
      logic do_mul;    // register product of selected operands
      logic mul_scale; // multiply sum by scale instead of activation by weight
      logic do_add;    // accumulate product
      logic clear;     // zero the accumulator
      logic load_out;  // capture result into output register
      logic out_scaled;// take scaled value as result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
      logic int8;
   } status_type;

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [7:0]  e;
      logic [3:0]  lz;
      logic [10:0] sh;
      ex  = h[14:10];
      man = h[9:0];
      lz  = 4'd0;
      for (int i = 9; i >= 0; i--) begin
         if (man[i] && lz == 4'd0) lz = 4'(10 - i);
      end
      sh = {1'b0, man} << lz;
      e  = 8'd113 - 8'(lz);
      if (ex == 5'd0) begin
         if (man == 10'd0) half_to_single = {h[15], 31'd0};
         else half_to_single = {h[15], e, sh[9:0], 13'd0};
      end else if (ex == 5'd31) begin
         half_to_single = {h[15], 8'hFF, man, 13'd0};
      end else begin
         half_to_single = {h[15], 8'(ex) + 8'd112, man, 13'd0};
      end
   endfunction

   function automatic logic [31:0] int8_to_single(input logic [7:0] v);
      logic [7:0] mag;
      logic [2:0] msb;
      logic [22:0] frac;
      mag = v[7] ? (8'd0 - v) : v;
      msb = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (mag[i]) msb = 3'(i);
      end
      frac = {mag, 15'd0} << (5'd8 - 5'(msb));
      if (mag == 8'd0) int8_to_single = 32'd0;
      else if (v == 8'h80) int8_to_single = 32'hC300_0000;
      else int8_to_single = {v[7], 8'd127 + 8'(msb), frac};
   endfunction

   function automatic logic is_nan(input logic [31:0] a);
      is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   // Round a positive magnitude: exponent e (biased, may be <=0), mantissa m with
   // hidden bit at bit 26 and guard/round/sticky below bit 3.
   function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                               input logic [26:0] m);
      logic [26:0] mm;
      logic [5:0]  rs;
      logic [24:0] r;
      logic signed [10:0] ee;
      logic        st;
      mm = m;
      ee = e;
      if (e < 11'sd1) begin
         rs = (11'sd1 - e > 11'sd27) ? 6'd27 : 6'(11'sd1 - e);
         st = |(m & ((27'd1 << rs) - 27'd1));
         mm = (m >> rs) | {26'd0, st};
         ee = 11'sd0;
      end
      r = {1'b0, mm[26:3]} + {24'd0, mm[2] & (mm[1] | mm[0] | mm[3])};
      if (ee == 11'sd0) begin
         round_pack = {s, 7'd0, r[23], r[22:0]};
      end else if (r[24]) begin
         if (ee + 11'sd1 >= 11'sd255) round_pack = {s, 8'hFF, 23'd0};
         else round_pack = {s, 8'(ee + 11'sd1), r[23:1]};
      end else if (ee >= 11'sd255) begin
         round_pack = {s, 8'hFF, 23'd0};
      end else begin
         round_pack = {s, 8'(ee), r[22:0]};
      end
   endfunction

endpackage

/* hdl/mpdp_if.sv */
// Interfaces: valid/ready channels for items and results
interface mpdp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] activation_bits;
   logic [31:0] weight_bits;
   logic [15:0] row_scale_bits;
   logic        last_element;
   modport source (output valid, activation_bits, weight_bits, row_scale_bits,
                   last_element, input ready);
   modport sink (input valid, activation_bits, weight_bits, row_scale_bits,
                 last_element, output ready);
endinterface

interface mpdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_bits;
   modport source (output valid, result_bits, input ready);
   modport sink (input valid, result_bits, output ready);
endinterface

/* hdl/mixed_precision_dot_product_unit.sv */
// Top level: fp32 dot-product accumulator with fp32/fp16/int8 weights
// Sequencing: an item is accepted in ST_IDLE, then multiplied, then added to the sum
//    by the loop-carried add; on the last item the result is offered after that add,
//    or in int8 mode after the row-scale multiply that follows it.
// Flow: a new item is taken only once the previous item's add has completed; the last item
//    holds the input until its result is transferred.
// Reset: synchronous, active high; clears the sum to +0 and the format to fp32.
module mixed_precision_dot_product_unit (
   input  logic                              clock,
   input  logic                              reset,
   mpdp_req_if.sink                          req,
   mpdp_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mpdp_pkg::AddrWidth+1:0]    csr_paddr,
   input  logic [mpdp_pkg::DataWidth-1:0]    csr_pwdata,
   output logic [mpdp_pkg::DataWidth-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import mpdp_pkg::*;

   fmt_type    fmt_ff;
   cmd_type    cmd;
   status_type status;

   // configuration register: write on the access phase of an APB transfer
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_FP32;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == {REG_WEIGHT_FORMAT, 2'b00}) begin
         fmt_ff <= fmt_type'(csr_pwdata[1:0]);
      end
   end
   assign csr_prdata = (csr_paddr == {REG_WEIGHT_FORMAT, 2'b00}) ?
                       {30'd0, fmt_ff} : '0;

   // controller sequences the item; the datapath holds sum, operands and result
   mpdp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status(status), .cmd(cmd)
   );

   mpdp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .fmt(fmt_ff),
      .activation_bits(req.activation_bits), .weight_bits(req.weight_bits),
      .row_scale_bits(req.row_scale_bits), .last_element(req.last_element),
      .result_bits(rsp.result_bits)
   );
endmodule

/* hdl/mpdp_fmul.sv */
// fp32 multiplier, one registered stage, round to nearest even
module mpdp_fmul (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] p
);
   import mpdp_pkg::*;

   logic [31:0] p_ff, p_in;
   logic        s, a_inf, b_inf, a_zero, b_zero;
   logic [23:0] ma, mb;
   logic [47:0] prod;
   logic [5:0]  lz;
   logic [47:0] norm;
   logic signed [10:0] ea, eb, e;
   logic [26:0] m;

   always_comb begin
      s      = a[31] ^ b[31];
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = a[30:0] == 31'd0;
      b_zero = b[30:0] == 31'd0;
      ma     = {a[30:23] != 8'd0, a[22:0]};
      mb     = {b[30:23] != 8'd0, b[22:0]};
      ea     = (a[30:23] == 8'd0) ? 11'sd1 : 11'(a[30:23]);
      eb     = (b[30:23] == 8'd0) ? 11'sd1 : 11'(b[30:23]);
      prod   = ma * mb;
      lz     = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (prod[i]) lz = 6'(47 - i);
      end
      norm   = prod << lz;
      e      = ea + eb - 11'sd126 - 11'(lz);
      m      = {norm[47:22], |norm[21:0]};
      if (is_nan(a) || is_nan(b) || (a_inf && b_zero) || (b_inf && a_zero)) p_in = CanonNan;
      else if (a_inf || b_inf) p_in = {s, 8'hFF, 23'd0};
      else if (a_zero || b_zero) p_in = {s, 31'd0};
      else p_in = round_pack(s, e, m);
   end

   always_ff @(posedge clock) begin
      if (en) p_ff <= p_in;
   end

   assign p = p_ff;
endmodule

/* hdl/mpdp_fadd.sv */
// fp32 adder, one registered stage, round to nearest even
module mpdp_fadd (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import mpdp_pkg::*;

   logic [31:0] y_ff, y_in, x, z;
   logic        swap, a_inf, b_inf, sub;
   logic [7:0]  ex, ez, dexp;
   logic [27:0] mx, mz, mzs, raw;
   logic [26:0] sum;
   logic [4:0]  lz;
   logic signed [10:0] e;

   always_comb begin
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      swap  = b[30:0] > a[30:0];
      x     = swap ? b : a;
      z     = swap ? a : b;
      ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ez    = (z[30:23] == 8'd0) ? 8'd1 : z[30:23];
      dexp  = ex - ez;
      // guard, round and sticky positions below the fraction
      mx    = {1'b0, x[30:23] != 8'd0, x[22:0], 3'b000};
      mz    = {1'b0, z[30:23] != 8'd0, z[22:0], 3'b000};
      if (dexp > 8'd27) mzs = {27'd0, mz != 28'd0};
      else mzs = (mz >> dexp) | {27'd0, |(mz & ((28'd1 << dexp) - 28'd1))};
      sub   = x[31] ^ z[31];
      raw   = sub ? (mx - mzs) : (mx + mzs);
      // raw has hidden bit at 26; bit 27 on carry
      lz    = 5'd0;
      for (int i = 0; i < 27; i++) begin
         if (raw[i]) lz = 5'(26 - i);
      end
      if (raw[27]) begin
         sum = {raw[27:2], |raw[1:0]};
         e   = 11'(ex) + 11'sd1;
      end else begin
         sum = raw[26:0] << lz;
         e   = 11'(ex) - 11'(lz);
      end
      if (is_nan(a) || is_nan(b) || (a_inf && b_inf && (a[31] != b[31]))) y_in = CanonNan;
      else if (a_inf) y_in = a;
      else if (b_inf) y_in = b;
      else if (raw == 28'd0) y_in = {a[31] & b[31], 31'd0};
      else y_in = round_pack(x[31], e, sum);
   end

   always_ff @(posedge clock) begin
      if (en) y_ff <= y_in;
   end

   assign y = y_ff;
endmodule

/* hdl/mpdp_datapath.sv */
// Datapath: operand capture, shared multiplier, accumulator adder, result register
module mpdp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mpdp_pkg::cmd_type    cmd,
   output mpdp_pkg::status_type status,
   input  mpdp_pkg::fmt_type    fmt,
   input  logic [31:0]          activation_bits,
   input  logic [31:0]          weight_bits,
   input  logic [15:0]          row_scale_bits,
   input  logic                 last_element,
   output logic [31:0]          result_bits
);
   import mpdp_pkg::*;

   logic [31:0] act_ff, wgt_ff, scale_ff, sum_ff, res_ff, wide_w, prod, addy, ma, mb;
   logic        last_ff, int8_ff;

   always_comb begin
      unique case (fmt)
         FMT_FP16: wide_w = half_to_single(weight_bits[15:0]);
         FMT_INT8: wide_w = int8_to_single(weight_bits[7:0]);
         default:  wide_w = weight_bits;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= activation_bits;
         wgt_ff   <= wide_w;
         scale_ff <= half_to_single(row_scale_bits);
         last_ff  <= last_element;
         int8_ff  <= fmt == FMT_INT8;
      end
   end

   assign ma = cmd.mul_scale ? sum_ff : act_ff;
   assign mb = cmd.mul_scale ? scale_ff : wgt_ff;

   mpdp_fmul u_fmul (.clock(clock), .en(cmd.do_mul), .a(ma), .b(mb), .p(prod));
   mpdp_fadd u_fadd (.clock(clock), .en(1'b1), .a(sum_ff), .b(prod), .y(addy));

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) sum_ff <= 32'd0;
      else if (cmd.do_add) sum_ff <= addy;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) res_ff <= cmd.out_scaled ? prod : addy;
   end

   assign status      = '{last: last_ff, int8: int8_ff};
   assign result_bits = res_ff;
endmodule

/* hdl/mpdp_ctrl.sv */
// Controller: sequences multiply, accumulate, scale and result transfer
module mpdp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mpdp_pkg::status_type status,
   output mpdp_pkg::cmd_type    cmd
);
   import mpdp_pkg::*;

   state_type state_ff, state_in;
   logic      add_wait_ff, add_wait_in;

   // ST_ADD and ST_SCALE each have a wait phase (add_wait_ff): the unit registers its result, then it is taken
   always_comb begin
      state_in    = state_ff;
      add_wait_in = 1'b0;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MUL;
         ST_MUL:   state_in = ST_ADD;
         ST_ADD: begin
            if (!add_wait_ff) add_wait_in = 1'b1;
            else if (!status.last) state_in = ST_IDLE;
            else if (status.int8) state_in = ST_SCALE;
            else state_in = ST_OUT;
         end
         ST_SCALE: begin
            if (!add_wait_ff) add_wait_in = 1'b1;
            else state_in = ST_OUT;
         end
         ST_OUT:   if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL:   cmd.do_mul = 1'b1;
         ST_ADD: begin
            cmd.do_add = add_wait_ff;
            // plain formats: take the finished sum as result and drop the accumulator
            if (add_wait_ff && status.last && !status.int8) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
            end
         end
         ST_SCALE: begin
            if (!add_wait_ff) begin
               cmd.do_mul    = 1'b1;
               cmd.mul_scale = 1'b1;
            end else begin
               cmd.load_out   = 1'b1;
               cmd.out_scaled = 1'b1;
               cmd.clear      = 1'b1;
            end
         end
         ST_OUT:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         add_wait_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         add_wait_ff <= add_wait_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept during result");
   a_out_after: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_ADD || $past(state_ff) == ST_SCALE))
      else $error("result without add");
   a_mul_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_MUL) else $error("no multiply");
`endif
endmodule
